[rtl/mpe_pkg.sv]
package mpe_pkg;

	// Field widths of the channels.
	localparam int RADIUS_W  = 9;
	localparam int COORD_W   = 10;
	localparam int CFG_IDX_W = 1;

	// Internal widths, sized for the 9-bit radius registers.
	localparam int X_W     = 10;
	localparam int Y_W     = 11;
	localparam int SQ_W    = 2 * RADIUS_W;
	localparam int SLOPE_W = 30;
	localparam int DEC_W   = 42;
	localparam int MUL_A_W = 29;
	localparam int MUL_B_W = SQ_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam int MAX_RADIUS_DEF = 511;

	localparam logic [RADIUS_W-1:0] RADIUS_X_RST = RADIUS_W'(150);
	localparam logic [RADIUS_W-1:0] RADIUS_Y_RST = RADIUS_W'(80);

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 1'b1;

	localparam logic REQ_ADVANCE = 1'b0;
	localparam logic REQ_START   = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_A,
		OP_SQ_B,
		OP_A2RB,
		OP_INIT,
		OP_R2_BT,
		OP_R2_BTT,
		OP_R2_AU,
		OP_R2_AUU,
		OP_R2_AB,
		OP_R2_DONE,
		OP_STEP,
		OP_DEC
	} mpe_op_t;

	typedef struct packed {
		mpe_op_t op;
		logic    mode;
	} mpe_cmd_t;

	typedef struct packed {
		logic active;
		logic need_r2;
	} mpe_status_t;

endpackage

[rtl/mpe_req_if.sv]
interface mpe_req_if import mpe_pkg::*; ();
	logic valid;
	logic ready;
	logic req_type;
	logic mirror_mode;

	modport source (output valid, req_type, mirror_mode, input ready);
	modport sink (input valid, req_type, mirror_mode, output ready);
endinterface

[rtl/mpe_point_if.sv]
interface mpe_point_if import mpe_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic                      last_point;

	modport source (output valid, point_x, point_y, last_point, input ready);
	modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

[rtl/mpe_cfg_if.sv]
interface mpe_cfg_if import mpe_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [RADIUS_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/mpe_ctrl.sv]
module mpe_ctrl import mpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_type,
	input  logic        in_mirror,
	output logic        in_ready,
	input  logic        out_ready,
	output logic        out_valid,
	input  mpe_status_t sts,
	output mpe_cmd_t    cmd
);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_SQ_A     = 13'b0000000000010,
		S_SQ_B     = 13'b0000000000100,
		S_A2RB     = 13'b0000000001000,
		S_INIT     = 13'b0000000010000,
		S_R2_BT    = 13'b0000000100000,
		S_R2_BTT   = 13'b0000001000000,
		S_R2_AU    = 13'b0000010000000,
		S_R2_AUU   = 13'b0000100000000,
		S_R2_AB    = 13'b0001000000000,
		S_R2_DONE  = 13'b0010000000000,
		S_STEP     = 13'b0100000000000,
		S_DEC      = 13'b1000000000000
	} mpe_state_t;

	mpe_state_t state_q, state_d;
	logic       out_valid_q;
	logic       in_acc;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.mode = in_mirror;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_type == REQ_START) begin
						cmd.op  = OP_LOAD;
						state_d = S_SQ_A;
					end else if (sts.active) begin
						// The first point of region two needs the decision value rebuilt.
						if (sts.need_r2) begin
							state_d = S_R2_BT;
						end else begin
							cmd.op  = OP_STEP;
							state_d = S_DEC;
						end
					end
				end
			end
			S_SQ_A: begin
				cmd.op  = OP_SQ_A;
				state_d = S_SQ_B;
			end
			S_SQ_B: begin
				cmd.op  = OP_SQ_B;
				state_d = S_A2RB;
			end
			S_A2RB: begin
				cmd.op  = OP_A2RB;
				state_d = S_INIT;
			end
			S_INIT: begin
				cmd.op  = OP_INIT;
				state_d = S_IDLE;
			end
			S_R2_BT: begin
				cmd.op  = OP_R2_BT;
				state_d = S_R2_BTT;
			end
			S_R2_BTT: begin
				cmd.op  = OP_R2_BTT;
				state_d = S_R2_AU;
			end
			S_R2_AU: begin
				cmd.op  = OP_R2_AU;
				state_d = S_R2_AUU;
			end
			S_R2_AUU: begin
				cmd.op  = OP_R2_AUU;
				state_d = S_R2_AB;
			end
			S_R2_AB: begin
				cmd.op  = OP_R2_AB;
				state_d = S_R2_DONE;
			end
			S_R2_DONE: begin
				cmd.op  = OP_R2_DONE;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.op  = OP_STEP;
				state_d = S_DEC;
			end
			S_DEC: begin
				cmd.op  = OP_DEC;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_STEP) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/mpe_datapath.sv]
module mpe_datapath import mpe_pkg::*; #(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [RADIUS_W-1:0]       cfg_data,
	input  mpe_cmd_t                  cmd,
	output mpe_status_t               sts,
	output logic signed [COORD_W-1:0] point_x,
	output logic signed [COORD_W-1:0] point_y,
	output logic                      last_point
);

	function automatic logic [RADIUS_W-1:0] clamp_radius(input logic [RADIUS_W-1:0] r);
		logic [RADIUS_W-1:0] v;
		v = r;
		if (int'(r) > MAX_RADIUS) begin
			v = RADIUS_W'(MAX_RADIUS);
		end
		return v;
	endfunction

	logic [RADIUS_W-1:0]       radius_x_q, radius_y_q, ra_q, rb_q;
	logic [SQ_W-1:0]           a2_q, b2_q;
	logic [PROD_W-1:0]         prod_q;
	logic [X_W-1:0]            x_q;
	logic signed [Y_W-1:0]     y_q;
	logic signed [SLOPE_W-1:0] dx_q, dy_q;
	logic signed [DEC_W-1:0]   dec_q;
	logic                      region2_q, active_q, mirrored_q, diag_q;
	logic signed [COORD_W-1:0] point_x_q, point_y_q;
	logic                      last_q;

	logic [X_W:0]              t_val;
	logic [RADIUS_W-1:0]       u_abs;
	logic [MUL_A_W-1:0]        mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic [PROD_W-1:0]         mul_p;
	logic signed [SLOPE_W-1:0] a2x2, b2x2;
	logic signed [DEC_W-1:0]   a2x4, b2x4, a2_ext, prod4, dxx4, dyx4;
	logic                      dec_pos, use_dx, use_dy, y_zero;

	assign y_zero = (y_q == '0);
	// In region two the term (2x+1) and |y-1| feed the rebuilt decision value.
	assign t_val  = {x_q, 1'b1};
	assign u_abs  = y_zero ? RADIUS_W'(1) : RADIUS_W'(y_q - Y_W'(1));

	assign a2x2   = SLOPE_W'({a2_q, 1'b0});
	assign b2x2   = SLOPE_W'({b2_q, 1'b0});
	assign a2x4   = DEC_W'({a2_q, 2'b00});
	assign b2x4   = DEC_W'({b2_q, 2'b00});
	assign a2_ext = DEC_W'(a2_q);
	assign prod4  = {prod_q[DEC_W-3:0], 2'b00};
	assign dxx4   = {{(DEC_W-SLOPE_W-2){dx_q[SLOPE_W-1]}}, dx_q, 2'b00};
	assign dyx4   = {{(DEC_W-SLOPE_W-2){dy_q[SLOPE_W-1]}}, dy_q, 2'b00};

	assign dec_pos = !dec_q[DEC_W-1] && (dec_q != '0);
	assign use_dx  = !region2_q || diag_q;
	assign use_dy  = region2_q || diag_q;

	assign sts.active  = active_q;
	assign sts.need_r2 = active_q && !region2_q && !(dx_q < dy_q);

	assign point_x    = point_x_q;
	assign point_y    = point_y_q;
	assign last_point = last_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_SQ_A: begin
				mul_a = MUL_A_W'(ra_q);
				mul_b = MUL_B_W'(ra_q);
			end
			OP_SQ_B: begin
				mul_a = MUL_A_W'(rb_q);
				mul_b = MUL_B_W'(rb_q);
			end
			OP_A2RB: begin
				mul_a = MUL_A_W'(a2_q);
				mul_b = MUL_B_W'(rb_q);
			end
			OP_R2_BT: begin
				mul_a = MUL_A_W'(b2_q);
				mul_b = MUL_B_W'(t_val);
			end
			OP_R2_BTT: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(t_val);
			end
			OP_R2_AU: begin
				mul_a = MUL_A_W'(a2_q);
				mul_b = MUL_B_W'(u_abs);
			end
			OP_R2_AUU: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(u_abs);
			end
			OP_R2_AB: begin
				mul_a = MUL_A_W'(a2_q);
				mul_b = b2_q;
			end
			default: begin
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_x_q <= RADIUS_X_RST;
			radius_y_q <= RADIUS_Y_RST;
			active_q   <= 1'b0;
			region2_q  <= 1'b0;
			mirrored_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RADIUS_X: radius_x_q <= cfg_data;
					REG_RADIUS_Y: radius_y_q <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (cmd.op)
				OP_LOAD: begin
					active_q   <= 1'b0;
					region2_q  <= 1'b0;
					mirrored_q <= cmd.mode;
				end
				OP_INIT: begin
					active_q  <= 1'b1;
					region2_q <= 1'b0;
				end
				OP_R2_DONE: region2_q <= 1'b1;
				OP_STEP: begin
					if (region2_q && y_zero) begin
						active_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op != OP_NONE && cmd.op != OP_LOAD && cmd.op != OP_INIT &&
			cmd.op != OP_STEP && cmd.op != OP_DEC && cmd.op != OP_R2_DONE) begin
			prod_q <= mul_p;
		end
		unique case (cmd.op)
			OP_LOAD: begin
				if (cmd.mode) begin
					ra_q <= clamp_radius(radius_y_q);
					rb_q <= clamp_radius(radius_x_q);
				end else begin
					ra_q <= clamp_radius(radius_x_q);
					rb_q <= clamp_radius(radius_y_q);
				end
			end
			OP_SQ_B: a2_q <= prod_q[SQ_W-1:0];
			OP_A2RB: b2_q <= prod_q[SQ_W-1:0];
			OP_INIT: begin
				x_q   <= '0;
				y_q   <= Y_W'(rb_q);
				dx_q  <= '0;
				dy_q  <= SLOPE_W'({prod_q, 1'b0});
				dec_q <= b2x4 - prod4 + a2_ext;
			end
			OP_R2_AU:   dec_q <= prod4 >>> 2;
			OP_R2_AB:   dec_q <= dec_q + prod4;
			OP_R2_DONE: dec_q <= dec_q - prod4;
			OP_STEP: begin
				point_x_q <= mirrored_q ? COORD_W'(-y_q) : COORD_W'(x_q);
				point_y_q <= mirrored_q ? COORD_W'(-x_q) : COORD_W'(y_q);
				last_q    <= region2_q && y_zero;
				if (!region2_q) begin
					x_q  <= x_q + 1'b1;
					dx_q <= dx_q + b2x2;
					if (!dec_q[DEC_W-1]) begin
						y_q    <= y_q - 1'b1;
						dy_q   <= dy_q - a2x2;
						diag_q <= 1'b1;
					end else begin
						diag_q <= 1'b0;
					end
				end else begin
					y_q  <= y_q - 1'b1;
					dy_q <= dy_q - a2x2;
					if (!dec_pos) begin
						x_q    <= x_q + 1'b1;
						dx_q   <= dx_q + b2x2;
						diag_q <= 1'b1;
					end else begin
						diag_q <= 1'b0;
					end
				end
			end
			OP_DEC: begin
				// Uses the slopes already moved by the step before.
				dec_q <= dec_q + (region2_q ? a2x4 : b2x4)
					+ (use_dx ? dxx4 : DEC_W'(0)) - (use_dy ? dyx4 : DEC_W'(0));
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/midpoint_ellipse_point_generator.sv]
// Channel   Direction  Payload                          Handshake
// req_ch    in         req_type, mirror_mode            valid / ready
// point_ch  out        point_x, point_y, last_point     valid / ready
// cfg_ch    in         index, data (radius_x, radius_y) valid / ready, always ready
//
// An advance request sets the point and the slopes first, then updates the
// decision value. The first point of region two first rebuilds the decision value
// with five products on one shared multiplier.
// A start request computes three products and then loads the trace state.
// After reset the block is idle and the radii are 150 and 80.
// Requests are held off while a request is being worked on, and while a point
// sits in the output register and is not taken.
module midpoint_ellipse_point_generator import mpe_pkg::*; #(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	mpe_req_if.sink      req_ch,
	mpe_point_if.source  point_ch,
	mpe_cfg_if.sink      cfg_ch
);

	mpe_cmd_t    cmd;
	mpe_status_t sts;
	logic        req_acc;

	assign cfg_ch.ready = 1'b1;
	assign req_acc      = req_ch.valid && req_ch.ready;

	mpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_ch.valid),
		.in_type   (req_ch.req_type),
		.in_mirror (req_ch.mirror_mode),
		.in_ready  (req_ch.ready),
		.out_ready (point_ch.ready),
		.out_valid (point_ch.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpe_datapath #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_ch.valid && cfg_ch.ready),
		.cfg_index  (cfg_ch.index),
		.cfg_data   (cfg_ch.data),
		.cmd        (cmd),
		.sts        (sts),
		.point_x    (point_ch.point_x),
		.point_y    (point_ch.point_y),
		.last_point (point_ch.last_point)
	);

	// A start request never produces a point.
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req_ch.req_type == REQ_START && !point_ch.valid) |=> !point_ch.valid)
		else $error("point produced by a start request");

	// An advance with no trace running produces nothing.
	a_idle_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req_ch.req_type == REQ_ADVANCE && !sts.active && !point_ch.valid)
		|=> !point_ch.valid)
		else $error("point produced while no trace is running");

	// Every step is followed by its decision update.
	a_step_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_STEP |=> cmd.op == OP_DEC)
		else $error("decision update missing after a step");

	// The region two rebuild starts with the output register empty.
	a_r2_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_R2_BT |-> !point_ch.valid)
		else $error("region two rebuild with a point pending");

endmodule
